// ----- rtl/core/fdtc_pkg.sv -----
`timescale 1ns / 1ps

package fdtc_pkg;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_PRE,
    OP_MUL_XZ,
    OP_P_LD,
    OP_MUL_RE,
    OP_R_LD,
    OP_MUL_IM,
    OP_R_ADD,
    OP_SQRT_P,
    OP_SP_LD,
    OP_SQRT_R,
    OP_SR_LD,
    OP_MUL_RESP,
    OP_MUL_IMSP,
    OP_DIV_MUL,
    OP_RE_LD,
    OP_IM_LD,
    OP_DIV_T,
    OP_T_LD,
    OP_SOLVE,
    OP_MUL_S1,
    OP_Q_LD,
    OP_Q_ADD,
    OP_DIV_Q,
    OP_FIN,
    OP_OUT
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic case1;
    logic r_gt_p;
    logic base_pos;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } status_t;

  localparam logic [1:0] CLS_ODD    = 2'd0;
  localparam logic [1:0] CLS_DOUBLE = 2'd1;
  localparam logic [1:0] CLS_VOLUME = 2'd2;

  localparam logic [63:0] RATIO_CAP = 64'h0000_0100_0000_0000;

endpackage

// ----- rtl/core/fdtc_ctrl.sv -----
`timescale 1ns / 1ps

module fdtc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fdtc_pkg::status_t st,
  output fdtc_pkg::op_t     op
);
  import fdtc_pkg::*;

  typedef enum logic [34:0] {
    S_IDLE  = 35'd1 << 0,
    S_PRE   = 35'd1 << 1,
    S_MXZ   = 35'd1 << 2,
    S_PLD   = 35'd1 << 3,
    S_MRE   = 35'd1 << 4,
    S_RLD   = 35'd1 << 5,
    S_MIM   = 35'd1 << 6,
    S_RADD  = 35'd1 << 7,
    S_CHK   = 35'd1 << 8,
    S_SQP   = 35'd1 << 9,
    S_WSQP  = 35'd1 << 10,
    S_SPLD  = 35'd1 << 11,
    S_SQR   = 35'd1 << 12,
    S_WSQR  = 35'd1 << 13,
    S_SRLD  = 35'd1 << 14,
    S_MRESP = 35'd1 << 15,
    S_DVRE  = 35'd1 << 16,
    S_WDVRE = 35'd1 << 17,
    S_RELD  = 35'd1 << 18,
    S_MIMSP = 35'd1 << 19,
    S_DVIM  = 35'd1 << 20,
    S_WDVIM = 35'd1 << 21,
    S_IMLD  = 35'd1 << 22,
    S_DVT   = 35'd1 << 23,
    S_WDVT  = 35'd1 << 24,
    S_TLD   = 35'd1 << 25,
    S_SOLVE = 35'd1 << 26,
    S_MS1   = 35'd1 << 27,
    S_QLD   = 35'd1 << 28,
    S_MIMQ  = 35'd1 << 29,
    S_QADD  = 35'd1 << 30,
    S_DVQ   = 35'd1 << 31,
    S_WDVQ  = 35'd1 << 32,
    S_FIN   = 35'd1 << 33,
    S_DONE  = 35'd1 << 34
  } state_t;

  state_t state_r, state_nxt;
  logic   scaled_r, scaled_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    scaled_nxt = scaled_r;
    op         = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        op         = OP_PRE;
        scaled_nxt = 1'b0;
        state_nxt  = st.case1 ? S_DONE : S_MXZ;
      end
      S_MXZ:  begin op = OP_MUL_XZ; state_nxt = S_PLD;  end
      S_PLD:  begin op = OP_P_LD;   state_nxt = S_MRE;  end
      S_MRE:  begin op = OP_MUL_RE; state_nxt = S_RLD;  end
      S_RLD:  begin op = OP_R_LD;   state_nxt = S_MIM;  end
      S_MIM:  begin op = OP_MUL_IM; state_nxt = S_RADD; end
      S_RADD: begin op = OP_R_ADD;  state_nxt = S_CHK;  end
      S_CHK: begin
        state_nxt = (st.r_gt_p && !scaled_r) ? S_SQP : S_DVT;
      end
      S_SQP:  begin op = OP_SQRT_P; state_nxt = S_WSQP; end
      S_WSQP: begin if (!st.sqrt_busy) state_nxt = S_SPLD; end
      S_SPLD: begin op = OP_SP_LD;  state_nxt = S_SQR;  end
      S_SQR:  begin op = OP_SQRT_R; state_nxt = S_WSQR; end
      S_WSQR: begin if (!st.sqrt_busy) state_nxt = S_SRLD; end
      S_SRLD: begin op = OP_SR_LD;  state_nxt = S_MRESP; end
      S_MRESP: begin op = OP_MUL_RESP; state_nxt = S_DVRE; end
      S_DVRE: begin op = OP_DIV_MUL; state_nxt = S_WDVRE; end
      S_WDVRE: begin if (!st.div_busy) state_nxt = S_RELD; end
      S_RELD: begin op = OP_RE_LD;  state_nxt = S_MIMSP; end
      S_MIMSP: begin op = OP_MUL_IMSP; state_nxt = S_DVIM; end
      S_DVIM: begin op = OP_DIV_MUL; state_nxt = S_WDVIM; end
      S_WDVIM: begin if (!st.div_busy) state_nxt = S_IMLD; end
      S_IMLD: begin
        op         = OP_IM_LD;
        scaled_nxt = 1'b1;
        state_nxt  = S_MRE;
      end
      S_DVT:  begin op = OP_DIV_T;  state_nxt = S_WDVT; end
      S_WDVT: begin if (!st.div_busy) state_nxt = S_TLD; end
      S_TLD:  begin op = OP_T_LD;   state_nxt = S_SOLVE; end
      S_SOLVE: begin op = OP_SOLVE; state_nxt = S_MS1; end
      S_MS1:  begin op = OP_MUL_S1; state_nxt = S_QLD;  end
      S_QLD:  begin op = OP_Q_LD;   state_nxt = S_MIMQ; end
      S_MIMQ: begin op = OP_MUL_IM; state_nxt = S_QADD; end
      S_QADD: begin
        op        = OP_Q_ADD;
        state_nxt = st.base_pos ? S_DVQ : S_FIN;
      end
      S_DVQ:  begin op = OP_DIV_Q;  state_nxt = S_WDVQ; end
      S_WDVQ: begin if (!st.div_busy) state_nxt = S_FIN; end
      S_FIN:  begin op = OP_FIN;    state_nxt = S_DONE; end
      S_DONE: begin
        if (st.out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      scaled_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      scaled_r <= scaled_nxt;
    end
  end

endmodule

// ----- rtl/core/fdtc_dp.sv -----
`timescale 1ns / 1ps

module fdtc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fdtc_pkg::op_t       op,
  output fdtc_pkg::status_t   st,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic signed [31:0]  in_t11,
  input  logic signed [31:0]  in_t12_re,
  input  logic signed [31:0]  in_t12_im,
  input  logic signed [31:0]  in_t22,
  input  logic signed [31:0]  in_t33,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_odd_power,
  output logic signed [31:0]  out_double_power,
  output logic signed [31:0]  out_volume_power,
  output logic [1:0]          out_scatter_class
);
  import fdtc_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > $signed(66'h0_0000_0000_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < $signed(66'h3_FFFF_FFFF_8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // halving, truncated toward zero
  function automatic logic signed [39:0] half_tz(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v + {39'd0, v[39]};
    return t >>> 1;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // captured pixel and threshold
  logic signed [31:0] a_r, b_r, c_r, d_r, e_r;
  logic signed [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [15:0]        thr_r, thr_nxt;

  // solve registers
  logic [31:0]        x_r, z_r, x_nxt, z_nxt;
  logic signed [31:0] re_r, im_r, re_nxt, im_nxt;
  logic [63:0]        p_r, r_r, q_r, mul_r;
  logic [63:0]        p_nxt, r_nxt, q_nxt, mul_nxt;
  logic [31:0]        sp_r, sr_r, t_r, sp_nxt, sr_nxt, t_nxt;
  logic [32:0]        s1_r, s1_nxt;
  logic signed [32:0] base_r, base_nxt;
  logic signed [31:0] odd_r, dbl_r, vol_r, odd_nxt, dbl_nxt, vol_nxt;
  logic [1:0]         cls_r, cls_nxt;

  // output word
  logic               ov_r, ov_nxt;
  logic signed [31:0] oodd_r, odbl_r, ovol_r, oodd_nxt, odbl_nxt, ovol_nxt;
  logic [1:0]         ocls_r, ocls_nxt;

  // bit-serial divider
  logic [63:0] dv_rem_r, dv_quo_r, dv_den_r, dv_rem_nxt, dv_quo_nxt, dv_den_nxt;
  logic [5:0]  dv_cnt_r, dv_cnt_nxt;
  logic        dv_busy_r, dv_busy_nxt;
  logic [64:0] dv_sh, dv_diff;
  logic [63:0] dv_a, dv_b;

  // two-bit-per-step square root
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r, sq_x_nxt, sq_res_nxt, sq_bit_nxt;
  logic [63:0] sq_trial;

  // pre-solve covariance terms
  logic signed [39:0] ax, bx, cx, dx, ex;
  logic signed [39:0] c11, c33, c13r, hh, adj, fv, c11r, c33r, c13rr, c13i;
  logic signed [39:0] vol1, vol2, thr_x;
  logic               case1;

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_full;

  logic [63:0]        num, den;
  logic [64:0]        qsum;
  logic [40:0]        ratio;
  logic signed [42:0] pw;
  logic signed [33:0] two_t;
  logic [31:0]        dq;

  always_comb begin
    ax = 40'(a_r);
    bx = 40'(b_r);
    cx = 40'(c_r);
    dx = 40'(d_r);
    ex = 40'(e_r);
    c11   = half_tz(ax + (bx <<< 1) + dx);
    c33   = half_tz(ax - (bx <<< 1) + dx);
    c13r  = half_tz(ax - dx);
    hh    = half_tz(ex);
    adj   = e_r[0] ? (e_r[31] ? -40'sd1 : 40'sd1) : 40'sd0;
    fv    = hh + (hh <<< 1) + adj;
    c11r  = c11 - fv;
    c33r  = c33 - fv;
    c13rr = c13r - hh;
    c13i  = -cx;
    vol1  = c11r + ex + c33r + (fv <<< 1);
    vol2  = (hh <<< 3) + (adj <<< 1);
    thr_x = {24'd0, thr_r};
    case1 = (c11r <= thr_x) || (c33r <= thr_x);
  end

  always_comb begin
    case (op)
      OP_MUL_XZ:   begin mul_a = {1'b0, x_r};          mul_b = {1'b0, z_r};          end
      OP_MUL_RE:   begin mul_a = {1'b0, mag32(re_r)};  mul_b = {1'b0, mag32(re_r)};  end
      OP_MUL_IM:   begin mul_a = {1'b0, mag32(im_r)};  mul_b = {1'b0, mag32(im_r)};  end
      OP_MUL_RESP: begin mul_a = {1'b0, mag32(re_r)};  mul_b = {1'b0, sp_r};         end
      OP_MUL_IMSP: begin mul_a = {1'b0, mag32(im_r)};  mul_b = {1'b0, sp_r};         end
      OP_MUL_S1:   begin mul_a = s1_r;                 mul_b = s1_r;                 end
      default:     begin mul_a = '0;                   mul_b = '0;                   end
    endcase
    mul_full = mul_a * mul_b;
  end

  always_comb begin
    num = (p_r > r_r) ? (p_r - r_r) : 64'd0;
    den = 64'(x_r) + 64'(z_r) + {31'd0, mag32(re_r), 1'b0};
    case (op)
      OP_DIV_T: begin dv_a = num;  dv_b = den; end
      OP_DIV_Q: begin dv_a = q_r;  dv_b = 64'(base_r[31:0]); end
      default:  begin dv_a = mul_r; dv_b = 64'(sr_r); end
    endcase
    dv_sh   = {dv_rem_r, dv_quo_r[63]};
    dv_diff = dv_sh - {1'b0, dv_den_r};
    sq_trial = sq_res_r + sq_bit_r;
    qsum  = {1'b0, q_r} + {1'b0, mul_r};
    ratio = (dv_quo_r > RATIO_CAP) ? RATIO_CAP[40:0] : dv_quo_r[40:0];
    if (!base_r[32] && (base_r != '0)) begin
      pw = 43'(base_r) + $signed({2'b00, ratio});
    end else begin
      pw = 43'(base_r);
    end
    two_t = $signed({1'b0, t_r, 1'b0});
    dq    = dv_quo_r[31:0];
  end

  always_comb begin
    st.case1     = case1;
    st.r_gt_p    = r_r > p_r;
    st.base_pos  = !base_r[32] && (base_r != '0);
    st.div_busy  = dv_busy_r;
    st.sqrt_busy = (sq_bit_r != '0);
    st.out_free  = !ov_r || !out_stall;
  end

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    thr_nxt = cfg_we ? cfg_wdata : thr_r;
    x_nxt = x_r; z_nxt = z_r; re_nxt = re_r; im_nxt = im_r;
    p_nxt = p_r; r_nxt = r_r; q_nxt = q_r; mul_nxt = mul_r;
    sp_nxt = sp_r; sr_nxt = sr_r; t_nxt = t_r; s1_nxt = s1_r; base_nxt = base_r;
    odd_nxt = odd_r; dbl_nxt = dbl_r; vol_nxt = vol_r; cls_nxt = cls_r;
    oodd_nxt = oodd_r; odbl_nxt = odbl_r; ovol_nxt = ovol_r; ocls_nxt = ocls_r;
    ov_nxt = out_stall ? ov_r : 1'b0;

    // divider iteration
    dv_rem_nxt = dv_rem_r; dv_quo_nxt = dv_quo_r; dv_den_nxt = dv_den_r;
    dv_cnt_nxt = dv_cnt_r; dv_busy_nxt = dv_busy_r;
    if (dv_busy_r) begin
      if (!dv_diff[64]) begin
        dv_rem_nxt = dv_diff[63:0];
        dv_quo_nxt = {dv_quo_r[62:0], 1'b1};
      end else begin
        dv_rem_nxt = dv_sh[63:0];
        dv_quo_nxt = {dv_quo_r[62:0], 1'b0};
      end
      dv_cnt_nxt = dv_cnt_r + 6'd1;
      if (dv_cnt_r == 6'd63) dv_busy_nxt = 1'b0;
    end

    // square root iteration
    sq_x_nxt = sq_x_r; sq_res_nxt = sq_res_r; sq_bit_nxt = sq_bit_r;
    if (sq_bit_r != '0) begin
      if (sq_x_r >= sq_trial) begin
        sq_x_nxt   = sq_x_r - sq_trial;
        sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_nxt = sq_res_r >> 1;
      end
      sq_bit_nxt = sq_bit_r >> 2;
    end

    if (op == OP_MUL_XZ || op == OP_MUL_RE || op == OP_MUL_IM || op == OP_MUL_RESP ||
        op == OP_MUL_IMSP || op == OP_MUL_S1) begin
      mul_nxt = mul_full[63:0];
    end

    case (op)
      OP_LOAD: begin
        a_nxt = in_t11; b_nxt = in_t12_re; c_nxt = in_t12_im;
        d_nxt = in_t22; e_nxt = in_t33;
      end
      OP_PRE: begin
        x_nxt   = sat32(66'(c11r));
        z_nxt   = sat32(66'(c33r));
        re_nxt  = sat32(66'(c13rr));
        im_nxt  = sat32(66'(c13i));
        odd_nxt = '0;
        dbl_nxt = '0;
        vol_nxt = case1 ? sat32(66'(vol1)) : sat32(66'(vol2));
      end
      OP_P_LD:   p_nxt = mul_r;
      OP_R_LD:   r_nxt = mul_r;
      OP_R_ADD:  r_nxt = r_r + mul_r;
      OP_SQRT_P: begin
        sq_x_nxt = p_r; sq_res_nxt = '0; sq_bit_nxt = 64'h4000_0000_0000_0000;
      end
      OP_SQRT_R: begin
        sq_x_nxt = r_r; sq_res_nxt = '0; sq_bit_nxt = 64'h4000_0000_0000_0000;
      end
      OP_SP_LD:  sp_nxt = sq_res_r[31:0];
      OP_SR_LD:  sr_nxt = sq_res_r[31:0];
      OP_DIV_MUL, OP_DIV_T, OP_DIV_Q: begin
        dv_rem_nxt  = '0;
        dv_quo_nxt  = dv_a;
        dv_den_nxt  = dv_b;
        dv_cnt_nxt  = '0;
        dv_busy_nxt = 1'b1;
      end
      OP_RE_LD:  re_nxt = re_r[31] ? $signed(-dq) : $signed(dq);
      OP_IM_LD:  im_nxt = im_r[31] ? $signed(-dq) : $signed(dq);
      OP_T_LD:   t_nxt = dq;
      OP_SOLVE: begin
        s1_nxt   = {1'b0, t_r} + {1'b0, mag32(re_r)};
        base_nxt = $signed({1'b0, z_r}) - $signed({1'b0, t_r});
      end
      OP_Q_LD:   q_nxt = mul_r;
      OP_Q_ADD:  q_nxt = qsum[64] ? '1 : qsum[63:0];
      OP_FIN: begin
        if (!re_r[31]) begin
          odd_nxt = sat32(66'(pw));
          dbl_nxt = sat32(66'(two_t));
        end else begin
          dbl_nxt = sat32(66'(pw));
          odd_nxt = sat32(66'(two_t));
        end
      end
      OP_OUT: begin
        if (odd_r > dbl_r && odd_r > vol_r)      cls_nxt = CLS_ODD;
        else if (dbl_r > odd_r && dbl_r > vol_r) cls_nxt = CLS_DOUBLE;
        else if (vol_r > odd_r && vol_r > dbl_r) cls_nxt = CLS_VOLUME;
        oodd_nxt = odd_r;
        odbl_nxt = dbl_r;
        ovol_nxt = vol_r;
        ocls_nxt = cls_nxt;
        ov_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      cls_r     <= CLS_ODD;
      ov_r      <= 1'b0;
      dv_busy_r <= 1'b0;
      sq_bit_r  <= '0;
    end else begin
      thr_r     <= thr_nxt;
      cls_r     <= cls_nxt;
      ov_r      <= ov_nxt;
      dv_busy_r <= dv_busy_nxt;
      sq_bit_r  <= sq_bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
    x_r <= x_nxt; z_r <= z_nxt; re_r <= re_nxt; im_r <= im_nxt;
    p_r <= p_nxt; r_r <= r_nxt; q_r <= q_nxt; mul_r <= mul_nxt;
    sp_r <= sp_nxt; sr_r <= sr_nxt; t_r <= t_nxt; s1_r <= s1_nxt; base_r <= base_nxt;
    odd_r <= odd_nxt; dbl_r <= dbl_nxt; vol_r <= vol_nxt;
    oodd_r <= oodd_nxt; odbl_r <= odbl_nxt; ovol_r <= ovol_nxt; ocls_r <= ocls_nxt;
    dv_rem_r <= dv_rem_nxt; dv_quo_r <= dv_quo_nxt; dv_den_r <= dv_den_nxt;
    dv_cnt_r <= dv_cnt_nxt;
    sq_x_r <= sq_x_nxt; sq_res_r <= sq_res_nxt;
  end

  assign out_valid         = ov_r;
  assign out_odd_power     = oodd_r;
  assign out_double_power  = odbl_r;
  assign out_volume_power  = ovol_r;
  assign out_scatter_class = ocls_r;

endmodule

// ----- rtl/core/freeman_three_component_decomposition.sv -----
`timescale 1ns / 1ps
// Channel  Handshake            Word
// in       in_valid / in_stall  in_t11, in_t12_re, in_t12_im, in_t22, in_t33 (s32 Q16.16)
// out      out_valid / out_stall out_odd_power, out_double_power, out_volume_power,
//                               out_scatter_class
// cfg      cfg_we               cfg_wdata = realizability threshold (u16)
//
// One word at a time. Volume-only pixels go from the pre-solve straight to output handoff.
// Other pixels run the full solve; the ratio divide is skipped when base <= 0, and a
// rescaled cross term adds a second pass through the solve; each divide is 64-step
// and each square root 32-step.
// rst_n is synchronous; it clears the held class, threshold and handshakes.
// The next word is taken while a finished result waits under out_stall.

module freeman_three_component_decomposition (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_t11,
  input  logic signed [31:0] in_t12_re,
  input  logic signed [31:0] in_t12_im,
  input  logic signed [31:0] in_t22,
  input  logic signed [31:0] in_t33,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_odd_power,
  output logic signed [31:0] out_double_power,
  output logic signed [31:0] out_volume_power,
  output logic [1:0]         out_scatter_class,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import fdtc_pkg::*;

  // controller sequences the shared multiplier, divider and square root
  op_t     op;
  status_t st;

  fdtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  // datapath: covariance terms, solve registers, output word and held class
  fdtc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_t11            (in_t11),
    .in_t12_re         (in_t12_re),
    .in_t12_im         (in_t12_im),
    .in_t22            (in_t22),
    .in_t33            (in_t33),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_odd_power     (out_odd_power),
    .out_double_power  (out_double_power),
    .out_volume_power  (out_volume_power),
    .out_scatter_class (out_scatter_class)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import fdtc_pkg::*;

  // one expected result word
  typedef struct {
    logic signed [31:0] odd_p;
    logic signed [31:0] dbl_p;
    logic signed [31:0] vol_p;
    logic [1:0]         cls;
  } power_word_t;

  // Scoreboard: holds its own copy of threshold and held class, predicts the
  // three powers per accepted pixel and compares results in order.
  class decomp_scoreboard;
    logic [15:0]  thresh;
    logic [1:0]   held_cls;
    power_word_t  pending[$];
    int           n_err;
    int           n_checked;
    int           n_case1;
    int           n_rescaled;
    int           n_odd_branch;
    int           n_even_branch;

    function new();
      thresh = 16'd0;
      held_cls = CLS_ODD;
      n_err = 0;
      n_checked = 0;
      n_case1 = 0;
      n_rescaled = 0;
      n_odd_branch = 0;
      n_even_branch = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    function logic [63:0] sq64(longint v);
      logic [63:0] m;
      m = abs64(v);
      return m * m;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] sum_clip(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // base plus capped ratio q/base; non-positive base drops the ratio
    function longint with_ratio(longint base, logic [63:0] q);
      logic [63:0] ratio;
      ratio = 0;
      if (base > 0) ratio = q / base;
      if (ratio > RATIO_CAP) ratio = RATIO_CAP;
      return base + longint'(ratio);
    endfunction

    function void note_pixel(logic signed [31:0] t11, logic signed [31:0] t12r,
                             logic signed [31:0] t12i, logic signed [31:0] t22,
                             logic signed [31:0] t33);
      longint a, b, c, d, e;
      longint c11, c13r, c13i, c22, c33, fv, odd_v, dbl_v, vol_v;
      longint x, z, re, im, sp, sr, fd, fs;
      logic [63:0] p, r, num, den;
      power_word_t w;
      a = t11; b = t12r; c = t12i; d = t22; e = t33;
      c11 = (a + 2 * b + d) / 2;
      c13r = (a - d) / 2;
      c13i = -c;
      c22 = e;
      c33 = (a - 2 * b + d) / 2;
      fv = 3 * c22 / 2;
      c11 -= fv;
      c33 -= fv;
      c13r -= fv / 3;
      if (c11 <= longint'(thresh) || c33 <= longint'(thresh)) begin
        n_case1++;
        odd_v = 0;
        dbl_v = 0;
        vol_v = c11 + c22 + c33 + 2 * fv;
      end else begin
        x = clip32(c11); z = clip32(c33);
        re = clip32(c13r); im = clip32(c13i);
        p = x * z;
        r = sq64(re) + sq64(im);
        if (r > p) begin
          n_rescaled++;
          sp = floor_sqrt(p);
          sr = floor_sqrt(r);
          re = re * sp / sr;
          im = im * sp / sr;
          r = sq64(re) + sq64(im);
        end
        num = p > r ? p - r : 0;
        if (re >= 0) begin
          n_odd_branch++;
          den = x + z + 2 * re;
          fd = num / den;
          fs = z - fd;
          odd_v = with_ratio(fs, sum_clip(sq64(fd + re), sq64(im)));
          dbl_v = 2 * fd;
        end else begin
          n_even_branch++;
          den = x + z + 2 * abs64(re);
          fs = num / den;
          fd = z - fs;
          dbl_v = with_ratio(fd, sum_clip(sq64(fs - re), sq64(im)));
          odd_v = 2 * fs;
        end
        vol_v = 8 * fv / 3;
      end
      odd_v = clip32(odd_v);
      dbl_v = clip32(dbl_v);
      vol_v = clip32(vol_v);
      // ties keep the previous pixel's class
      if (odd_v > dbl_v && odd_v > vol_v) held_cls = CLS_ODD;
      else if (dbl_v > odd_v && dbl_v > vol_v) held_cls = CLS_DOUBLE;
      else if (vol_v > odd_v && vol_v > dbl_v) held_cls = CLS_VOLUME;
      w.odd_p = odd_v[31:0];
      w.dbl_p = dbl_v[31:0];
      w.vol_p = vol_v[31:0];
      w.cls = held_cls;
      pending.push_back(w);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, n_checked);
      n_err++;
    endtask

    task check_word(logic signed [31:0] odd_p, logic signed [31:0] dbl_p,
                    logic signed [31:0] vol_p, logic [1:0] cls);
      power_word_t w;
      if (pending.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      w = pending.pop_front();
      if (odd_p !== w.odd_p) report("odd_power", odd_p, w.odd_p);
      if (dbl_p !== w.dbl_p) report("double_power", dbl_p, w.dbl_p);
      if (vol_p !== w.vol_p) report("volume_power", vol_p, w.vol_p);
      if (cls !== w.cls) report("scatter_class", cls, w.cls);
      n_checked++;
    endtask
  endclass

  localparam int DRAIN_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_t11, in_t12_re, in_t12_im, in_t22, in_t33;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_odd_power, out_double_power, out_volume_power;
  logic [1:0]         out_scatter_class;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;

  decomp_scoreboard sb;
  longint cycle_cnt;
  bit     hold_long;     // receiver long hold-off request
  bit     rx_quiet;      // receiver stall-free stretch
  int     n_sent;

  freeman_three_component_decomposition u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_t11           (in_t11),
    .in_t12_re        (in_t12_re),
    .in_t12_im        (in_t12_im),
    .in_t22           (in_t22),
    .in_t33           (in_t33),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_odd_power    (out_odd_power),
    .out_double_power (out_double_power),
    .out_volume_power (out_volume_power),
    .out_scatter_class(out_scatter_class),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_cnt, sb.pending.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall per word, occasional long hold-off so the block
  // backs up and must stall its input. Checks sample at the edge.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_long = 0;
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      // wait for a word to be taken
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_word(out_odd_power, out_double_power, out_volume_power,
                    out_scatter_class);
    end
  end

  // one pixel, after a random idle gap unless no_gap is set; held until accepted
  task send_pixel(logic signed [31:0] t11, logic signed [31:0] t12r,
                  logic signed [31:0] t12i, logic signed [31:0] t22,
                  logic signed [31:0] t33, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_t11    <= t11;
    in_t12_re <= t12r;
    in_t12_im <= t12i;
    in_t22    <= t22;
    in_t33    <= t33;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_pixel(t11, t12r, t12i, t22, t33);
    n_sent++;
  endtask

  task stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all outstanding words, then let the block settle
  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // threshold change, only with the block idle
  task set_threshold(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.thresh = v;
  endtask

  function logic signed [31:0] rand32();
    return $urandom();
  endfunction

  // Realistic pixel: non-negative diagonal, cross terms bounded by the diagonal's scale
  // so most land past case 1; scale spans small to near-overflow.
  task send_realistic(bit no_gap);
    int sh;
    logic signed [31:0] t11, t22, t33, t12r, t12i;
    sh = $urandom_range(4, 28);
    t11 = $urandom() >> (32 - sh);
    t22 = $urandom() >> (32 - sh);
    t33 = $urandom() >> (34 - sh);
    t12r = $signed($urandom() >> (33 - sh)) * (($urandom() & 1) ? 1 : -1);
    t12i = $signed($urandom() >> (32 - sh)) * (($urandom() & 1) ? 1 : -1);
    send_pixel(t11, t12r, t12i, t22, t33, no_gap);
  endtask

  // random phase: mostly realistic pixels, some raw noise
  task random_phase(int count);
    bit quick;
    for (int i = 0; i < count; i++) begin
      quick = (i % 100) < 15;   // stretch with no sender idling
      if ($urandom_range(0, 9) < 8) send_realistic(quick);
      else send_pixel(rand32(), rand32(), rand32(), rand32(), rand32(), quick);
    end
    stop_sending();
  endtask

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  initial begin
    sb = new();
    n_sent = 0;
    hold_long = 0;
    rx_quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_t11 = 0; in_t12_re = 0; in_t12_im = 0; in_t22 = 0; in_t33 = 0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, case 1, both bounce branches, rescale, ties
    send_pixel(0, 0, 0, 0, 0, 0);                     // all tie: class held
    send_pixel(SMAX, SMAX, SMAX, SMAX, SMAX, 0);
    send_pixel(SMIN, SMIN, SMIN, SMIN, SMIN, 0);
    send_pixel(SMAX, 0, SMIN, SMAX, 0, 0);
    send_pixel(SMIN, SMAX, SMAX, SMIN, SMAX, 0);
    send_pixel(-1, -1, -1, -1, -1, 0);
    send_pixel(0, 0, 0, 0, ONE, 0);                    // pure volume
    send_pixel(4 * ONE, 0, 0, ONE, 0, 0);              // odd branch, re >= 0
    send_pixel(ONE, 0, 0, 4 * ONE, 0, 0);              // even branch, re < 0
    send_pixel(4 * ONE, 0, 40 * ONE, ONE, 0, 0);       // cross term rescaled
    send_pixel(ONE, ONE / 4, -30 * ONE, 5 * ONE, ONE / 8, 0);
    send_pixel(2 * ONE, 0, 0, 2 * ONE, 0, 0);          // re zero
    send_pixel(SMAX, 0, 0, SMAX, 0, 0);                // wide C11, C33
    send_pixel(SMAX, 0, SMAX, SMIN, 0, 0);
    send_pixel(3, 0, 0, 3, 0, 0);                      // tiny, just above zero
    send_pixel(ONE, 0, 0, ONE, 0, 0);                  // equal odd/double: held
    send_pixel(SMAX, SMIN, 0, SMAX, SMIN, 0);
    stop_sending();
    drain();

    // threshold at maximum, then two small pixels above it and a random phase
    set_threshold(16'hFFFF);
    send_pixel(ONE, 0, 0, ONE, 0, 0);
    send_pixel(3 * ONE, 0, 0, 3 * ONE, 0, 0);
    random_phase(150);
    drain();

    // back-pressure: hold the receiver long while the sender keeps offering
    set_threshold(16'h0001);
    hold_long = 1;
    random_phase(150);
    drain();

    set_threshold(16'h8000);
    rx_quiet = 1;
    random_phase(100);
    rx_quiet = 0;
    drain();

    set_threshold(16'h0000);
    random_phase(200);
    drain();

    $display("covered %0d pixels: %0d volume-only, %0d rescaled, %0d odd-branch, %0d even-branch",
             n_sent, sb.n_case1, sb.n_rescaled, sb.n_odd_branch, sb.n_even_branch);
    $display("thresholds 0, 1, 0x8000 and 0xFFFF; %0d words checked, %0d mismatches",
             sb.n_checked, sb.n_err);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
